FILE: rtl/core/smrq_pkg.sv
// Shared types and constants of the sorted multiset rank query block.
// Holds the item structs, action and status codes, and the cell chain sizing.
// No dependencies; every other file of the block imports it.
package smrq_pkg;

  // Field widths
  localparam int KEY_W  = 60;
  localparam int ACT_W  = 2;
  localparam int RANK_W = 3;
  localparam int ST_W   = 2;

  // Store sizing
  localparam int CAPACITY = 1024;
  localparam int MAX_RANK = 5;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Neighbor windows seen by each cell: itself plus MAX_RANK cells on each side
  localparam int WIN_W     = MAX_RANK + 1;
  localparam int WIN_IDX_W = $clog2(WIN_W);

  // Result merge: cells are ORed per group, then the groups are ORed
  localparam int GROUP_LOG  = ($clog2(CAPACITY) + 1) / 2;
  localparam int GROUP_SIZE = 1 << GROUP_LOG;
  localparam int NUM_GROUPS = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LE     = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GE     = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_INSERTED = 2'd0;
  localparam logic [ST_W-1:0] ST_FOUND    = 2'd1;
  localparam logic [ST_W-1:0] ST_SHORT    = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [KEY_W-1:0]  key;
    logic [RANK_W-1:0] rank;
  } req_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] answer;
  } rsp_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic                 ins;
    logic                 sel_le;
    logic [WIN_IDX_W-1:0] k;
  } cell_cmd_t;

endpackage

FILE: rtl/core/sorted_multiset_rank_query.sv
// Top level of the sorted multiset rank query block.
// Builds the chain of smrq_cell instances, the grouped result merge and the control.
// Depends on smrq_pkg and smrq_cell.
//
//   channel | handshake            | payload        | role
//   --------+----------------------+----------------+-----------------------------
//   req     | req_valid, req_stall | req (req_t)    | insert or rank query item
//   rsp     | rsp_valid, rsp_stall | rsp (rsp_t)    | one status and answer per item
//
// Each item passes an exec step, where every cell compares against the key and shifts
// on insert, and a merge step, where the per-group picks are merged into the result.
// With rsp not stalled a new item is taken in the merge step of the one before.
// Reset clears the fill count and control; stored values need no clearing pass.
// A stalled rsp holds the finished result; one more item may be taken and executed,
// then req stays stalled in the merge step until the held result is taken.
module sorted_multiset_rank_query (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  smrq_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output smrq_pkg::rsp_t rsp
);
  import smrq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_MERGE
  } state_t;

  state_t           state;
  req_t             cmd;
  logic [CNT_W-1:0] count;
  logic             full_q;
  logic             full;
  logic             rank_ok;
  logic             rsp_free;
  logic             req_take;
  cell_cmd_t        ccmd;
  rsp_t             rsp_next;

  logic [KEY_W-1:0]    cell_value [CAPACITY];
  logic [KEY_W-1:0]    cell_pick  [CAPACITY];
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_gt;
  logic [CAPACITY-1:0] cell_hit;

  logic [KEY_W-1:0]      grp_val_next [NUM_GROUPS];
  logic [KEY_W-1:0]      grp_val      [NUM_GROUPS];
  logic [NUM_GROUPS-1:0] grp_hit_next;
  logic [NUM_GROUPS-1:0] grp_hit;
  logic [KEY_W-1:0]      merged_val;
  logic                  merged_hit;

  // Handshake
  assign rsp_free  = !rsp_valid || !rsp_stall;
  assign req_stall = !((state == S_IDLE) || ((state == S_MERGE) && rsp_free));
  assign req_take  = req_valid && !req_stall;

  assign full    = (count == CNT_W'(CAPACITY));
  assign rank_ok = (cmd.rank != '0) && (32'(cmd.rank) <= 32'(MAX_RANK));

  // Broadcast the command; clamp k so a bad rank still indexes inside the window
  assign ccmd.key    = cmd.key;
  assign ccmd.ins    = (state == S_EXEC) && (cmd.action == ACT_INSERT) && !full;
  assign ccmd.sel_le = (cmd.action == ACT_LE);
  assign ccmd.k      = rank_ok ? WIN_IDX_W'(cmd.rank) : WIN_IDX_W'(1);

  // Chain of cells with neighbor compare windows
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [WIN_W-1:0] le_win;
    logic [WIN_W-1:0] lt_win;
    logic [KEY_W-1:0] prev_value;
    logic             prev_gt;

    for (genvar d = 0; d < WIN_W; d++) begin : g_win
      if (i + d < CAPACITY) begin : g_le_in
        assign le_win[d] = cell_le[i + d];
      end else begin : g_le_out
        assign le_win[d] = 1'b0;
      end
      if (i - d >= 0) begin : g_lt_in
        assign lt_win[d] = cell_lt[i - d];
      end else if (i - d == -1) begin : g_lt_edge
        assign lt_win[d] = 1'b1;
      end else begin : g_lt_out
        assign lt_win[d] = 1'b0;
      end
    end

    if (i == 0) begin : g_head
      assign prev_value = ccmd.key;
      assign prev_gt    = 1'b0;
    end else begin : g_link
      assign prev_value = cell_value[i - 1];
      assign prev_gt    = cell_gt[i - 1];
    end

    smrq_cell u_cell (
      .clk        (clk),
      .cmd        (ccmd),
      .live       (count > CNT_W'(i)),
      .prev_value (prev_value),
      .prev_gt    (prev_gt),
      .le_win     (le_win),
      .lt_win     (lt_win),
      .value      (cell_value[i]),
      .le         (cell_le[i]),
      .lt         (cell_lt[i]),
      .gt         (cell_gt[i]),
      .hit        (cell_hit[i]),
      .pick       (cell_pick[i])
    );
  end

  // Merge the picks of each group
  for (genvar g = 0; g < NUM_GROUPS; g++) begin : g_grp
    logic grp_any;

    always_comb begin
      grp_val_next[g] = '0;
      grp_any         = 1'b0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (g * GROUP_SIZE + j < CAPACITY) begin
          grp_val_next[g] = grp_val_next[g] | cell_pick[g * GROUP_SIZE + j];
          grp_any         = grp_any | cell_hit[g * GROUP_SIZE + j];
        end
      end
    end

    assign grp_hit_next[g] = grp_any;

    always_ff @(posedge clk) begin
      if (state == S_EXEC) begin
        grp_val[g] <= grp_val_next[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EXEC) begin
      grp_hit <= grp_hit_next;
    end
  end

  // Merge the groups
  always_comb begin
    merged_val = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      merged_val = merged_val | grp_val[g];
    end
  end
  assign merged_hit = |grp_hit;

  // Form the result
  always_comb begin
    rsp_next.status = ST_SHORT;
    rsp_next.answer = '0;
    unique case (cmd.action) inside
      ACT_INSERT: begin
        rsp_next.status = full_q ? ST_FULL : ST_INSERTED;
      end
      ACT_LE, ACT_GE: begin
        if (rank_ok && merged_hit) begin
          rsp_next.status = ST_FOUND;
          rsp_next.answer = merged_val;
        end
      end
      default: begin
        rsp_next.status = ST_SHORT;
      end
    endcase
  end

  // Control and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      // Raise the result in the merge step, drop it once taken
      if ((state == S_MERGE) && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            cmd   <= req;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          full_q <= full;
          if (ccmd.ins) begin
            count <= CNT_W'(count + 1'b1);
          end
          state <= S_MERGE;
        end
        S_MERGE: begin
          if (rsp_free) begin
            rsp <= rsp_next;
            if (req_take) begin
              cmd   <= req;
              state <= S_EXEC;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_single_target: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) |-> $onehot0(cell_hit))
    else $error("more than one cell flagged as query target");

  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    ((state == S_EXEC) && ccmd.ins) |=> (count == CNT_W'($past(count) + 1'b1)))
    else $error("insert did not advance the fill count");

  a_rsp_from_merge: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == S_MERGE))
    else $error("result raised outside the merge step");
`endif

endmodule

FILE: rtl/core/smrq_cell.sv
// One cell of the sorted chain: holds one stored value and compares it with the key.
// Shifts in its left neighbor's value on insert, flags itself as the query target.
// Depends on smrq_pkg.
module smrq_cell (
  input  logic                          clk,
  input  smrq_pkg::cell_cmd_t           cmd,
  input  logic                          live,
  input  logic [smrq_pkg::KEY_W-1:0]    prev_value,
  input  logic                          prev_gt,
  input  logic [smrq_pkg::WIN_W-1:0]    le_win,
  input  logic [smrq_pkg::WIN_W-1:0]    lt_win,
  output logic [smrq_pkg::KEY_W-1:0]    value,
  output logic                          le,
  output logic                          lt,
  output logic                          gt,
  output logic                          hit,
  output logic [smrq_pkg::KEY_W-1:0]    pick
);
  import smrq_pkg::*;

  logic [KEY_W-1:0]     value_next;
  logic [WIN_IDX_W-1:0] k_less;

  // Compare the held value with the key; an empty cell sorts above everything
  assign le = live && (value <= cmd.key);
  assign lt = live && (value < cmd.key);
  assign gt = !le;

  // Shift right where the left neighbor is above the key, take the key at the boundary
  always_comb begin
    if (prev_gt) begin
      value_next = prev_value;
    end else if (gt) begin
      value_next = cmd.key;
    end else begin
      value_next = value;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      value <= value_next;
    end
  end

  // Flag the target: k-th at or below the key, or k-th at or above it
  assign k_less = cmd.k - WIN_IDX_W'(1);
  assign hit = cmd.sel_le ? (le_win[k_less] && !le_win[cmd.k])
                          : (live && lt_win[cmd.k] && !lt_win[k_less]);
  assign pick = hit ? value : '0;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for sorted_multiset_rank_query: directed, random, back-to-back and full-store item streams.
// A shadow sorted store predicts each status and answer; depends on smrq_pkg and the RTL.
module tb_top;
  import smrq_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MAX    = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow copy of the sorted store
  logic [KEY_W-1:0] shadow_vals [CAPACITY];
  int unsigned      shadow_fill = 0;

  rsp_t awaited_answers [$];
  int   error_count = 0;
  int   items_sent = 0;
  int   n_stored = 0, n_found = 0, n_short = 0, n_refused = 0;
  bit   src_idle_en = 1'b1;
  bit   sink_idle_en = 1'b1;
  int   stall_left = 0;

  sorted_multiset_rank_query i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Count stored values below bound, or at most bound when incl is set
  function automatic int unsigned shadow_count(logic [KEY_W-1:0] bound, bit incl);
    int unsigned c = 0;
    for (int unsigned i = 0; i < shadow_fill; i++) begin
      if (incl ? (shadow_vals[i] <= bound) : (shadow_vals[i] < bound)) c++;
    end
    return c;
  endfunction

  // Apply one item to the shadow store and return the status and answer it must give
  function automatic rsp_t shadow_apply(req_t item);
    rsp_t        res;
    int unsigned n;
    int unsigned k;
    res.status = ST_SHORT;
    res.answer = '0;
    k = 32'(item.rank);
    case (item.action)
      ACT_INSERT: begin
        if (shadow_fill >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          // equal values stay ahead of the new one
          n = shadow_count(item.key, 1'b1);
          for (int unsigned i = shadow_fill; i > n; i--) shadow_vals[i] = shadow_vals[i-1];
          shadow_vals[n] = item.key;
          shadow_fill++;
          res.status = ST_INSERTED;
        end
      end
      ACT_LE: begin
        if (k >= 1 && k <= MAX_RANK) begin
          n = shadow_count(item.key, 1'b1);
          if (n >= k) begin
            res.status = ST_FOUND;
            res.answer = shadow_vals[n-k];
          end
        end
      end
      ACT_GE: begin
        if (k >= 1 && k <= MAX_RANK) begin
          n = shadow_count(item.key, 1'b0);
          if (n + k - 1 < shadow_fill) begin
            res.status = ST_FOUND;
            res.answer = shadow_vals[n+k-1];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_item(logic [ACT_W-1:0] act, logic [KEY_W-1:0] key,
                                     logic [RANK_W-1:0] rank);
    req_t item;
    item.action = act;
    item.key    = key;
    item.rank   = rank;
    return item;
  endfunction

  // Keys biased toward duplicates, stored neighbors and the range ends
  function automatic logic [KEY_W-1:0] rand_key();
    logic [KEY_W-1:0] base;
    case ($urandom_range(0, 9)) inside
      0, 9: rand_key = KEY_W'({$urandom, $urandom});
      1: rand_key = $urandom_range(0, 1) ? KEY_MAX : '0;
      [2:4]: rand_key = KEY_W'($urandom_range(0, 40));
      [5:7]: begin
        if (shadow_fill == 0) begin
          rand_key = KEY_W'($urandom_range(0, 40));
        end else begin
          base = shadow_vals[$urandom_range(0, shadow_fill - 1)];
          rand_key = base + KEY_W'($urandom_range(0, 2)) - KEY_W'(1);
        end
      end
      default: rand_key = KEY_MAX - KEY_W'($urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [RANK_W-1:0] rand_rank();
    case ($urandom_range(0, 19))
      0: rand_rank = '0;
      1: rand_rank = RANK_W'($urandom_range(MAX_RANK + 1, 7));
      default: rand_rank = RANK_W'($urandom_range(1, MAX_RANK));
    endcase
  endfunction

  function automatic req_t random_item(int unsigned insert_pct);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < insert_pct) begin
      return make_item(ACT_INSERT, rand_key(), RANK_W'($urandom_range(0, 7)));
    end
    if (p < 96) return make_item($urandom_range(0, 1) ? ACT_LE : ACT_GE, rand_key(), rand_rank());
    return make_item(ACT_UNUSED, rand_key(), RANK_W'($urandom_range(0, 7)));
  endfunction

  // Send one item, wait for it to be taken and record what it must return
  task automatic send_item(req_t item);
    int gap;
    bit taken;
    gap = src_idle_en ? $urandom_range(0, 8) : 0;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (req_stall === 1'b0);
      @(posedge clk);
    end
    awaited_answers.push_back(shadow_apply(item));
    items_sent++;
  endtask

  // Hold off the sender until every awaited answer has come back
  task automatic wait_for_drain();
    req_valid <= 1'b0;
    do @(posedge clk); while (awaited_answers.size() != 0);
  endtask

  task automatic test_directed();
    send_item(make_item(ACT_LE, '0, 3'd1));
    send_item(make_item(ACT_GE, KEY_MAX, 3'(MAX_RANK)));
    send_item(make_item(ACT_INSERT, '0, 3'd7));
    send_item(make_item(ACT_INSERT, KEY_MAX, 3'd0));
    send_item(make_item(ACT_INSERT, 60'd5, 3'd2));
    send_item(make_item(ACT_INSERT, 60'd5, 3'd5));
    send_item(make_item(ACT_INSERT, 60'd5, 3'd1));
    send_item(make_item(ACT_LE, KEY_MAX, 3'd1));
    send_item(make_item(ACT_LE, 60'd5, 3'd3));
    send_item(make_item(ACT_LE, 60'd5, 3'd4));
    send_item(make_item(ACT_LE, 60'd5, 3'(MAX_RANK)));
    send_item(make_item(ACT_LE, 60'd4, 3'd1));
    send_item(make_item(ACT_GE, '0, 3'd1));
    send_item(make_item(ACT_GE, 60'd1, 3'd3));
    send_item(make_item(ACT_GE, 60'd6, 3'd1));
    send_item(make_item(ACT_GE, 60'd6, 3'd2));
    send_item(make_item(ACT_GE, KEY_MAX, 3'd1));
    // rank out of range and the unused action, then one in-range query
    send_item(make_item(ACT_LE, KEY_MAX, 3'd0));
    send_item(make_item(ACT_GE, '0, 3'd6));
    send_item(make_item(ACT_LE, KEY_MAX, 3'd7));
    send_item(make_item(ACT_UNUSED, 60'd5, 3'd1));
    send_item(make_item(ACT_LE, KEY_MAX, 3'd5));
    wait_for_drain();
  endtask

  // Random mixes in chunks, each with its own idling and insert share
  task automatic test_random_mix(int unsigned n_chunks);
    int unsigned pct;
    for (int unsigned c = 0; c < n_chunks; c++) begin
      src_idle_en  = $urandom_range(0, 3) != 0;
      sink_idle_en = $urandom_range(0, 3) != 0;
      pct = $urandom_range(25, 65);
      repeat (50) send_item(random_item(pct));
      if (c % 4 == 3) wait_for_drain();
    end
    wait_for_drain();
  endtask

  task automatic test_back_to_back();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (60) send_item(random_item(40));
    wait_for_drain();
  endtask

  // Fill the store to capacity, then check refused inserts and queries on a full store
  task automatic test_full_store();
    src_idle_en  = 1'b0;
    sink_idle_en = 1'($urandom_range(0, 1));
    while (shadow_fill < CAPACITY) send_item(make_item(ACT_INSERT, rand_key(), 3'd0));
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    send_item(make_item(ACT_INSERT, KEY_MAX, 3'd0));
    send_item(make_item(ACT_INSERT, '0, 3'd7));
    send_item(make_item(ACT_INSERT, rand_key(), 3'd3));
    send_item(make_item(ACT_GE, '0, 3'd1));
    send_item(make_item(ACT_LE, KEY_MAX, 3'(MAX_RANK)));
    repeat (30) send_item(random_item(10));
    wait_for_drain();
  endtask

  // Check each result against the oldest awaited answer; draw the next stall
  always @(posedge clk) begin
    if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
      if (awaited_answers.size() == 0) begin
        $error("unexpected result: status %0d answer %0h", rsp.status, rsp.answer);
        error_count++;
      end else begin
        automatic rsp_t want = awaited_answers.pop_front();
        if (rsp.status !== want.status) begin
          $error("status mismatch: expected %0d, got %0d", want.status, rsp.status);
          error_count++;
        end
        if (rsp.answer !== want.answer) begin
          $error("answer mismatch: expected %0h, got %0h", want.answer, rsp.answer);
          error_count++;
        end
        case (want.status)
          ST_INSERTED: n_stored++;
          ST_FOUND:    n_found++;
          ST_SHORT:    n_short++;
          default:     n_refused++;
        endcase
      end
      stall_left = sink_idle_en ? $urandom_range(0, 8) : 0;
    end
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_mix(11);
    test_back_to_back();
    test_full_store();
    wait_for_drain();
    repeat (20) @(posedge clk);
    if (awaited_answers.size() != 0) begin
      $error("%0d results never arrived", awaited_answers.size());
      error_count++;
    end
    $display("Run covered %0d items: %0d values stored, %0d found by rank query,",
             items_sent, n_stored, n_found);
    $display("%0d short or invalid queries, %0d inserts refused by the full store.",
             n_short, n_refused);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(2_000_000);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
